/* src/ps2mt_pkg.sv */
// Package for the PS/2 mouse packet cursor tracker: widths, header bit
// positions, framing phases, button event codes and register indexes.
// No dependencies.
`default_nettype none

package ps2mt_pkg;

  localparam int COORD_BITS_DEF = 13;   // default cursor register width
  localparam int SCREEN_BITS    = 13;   // width of the screen limit registers
  localparam int CFG_IDX_BITS   = 8;    // width of the register index
  localparam int EVT_BITS       = 2;

  localparam logic [SCREEN_BITS-1:0] SCREEN_WIDTH_RST  = 13'd1023;
  localparam logic [SCREEN_BITS-1:0] SCREEN_HEIGHT_RST = 13'd767;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_HEIGHT = 8'd1;

  // header byte bit positions
  localparam int HDR_Y_OVF = 7;
  localparam int HDR_X_OVF = 6;
  localparam int HDR_Y_SGN = 5;
  localparam int HDR_X_SGN = 4;
  localparam int HDR_SYNC  = 3;
  localparam int HDR_BTN3  = 2;
  localparam int HDR_BTN2  = 1;
  localparam int HDR_BTN1  = 0;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_X      = 2'd1,
    PH_Y      = 2'd2
  } phase_t;

  typedef enum logic [EVT_BITS-1:0] {
    BTN_NONE    = 2'd0,
    BTN_PRESS   = 2'd1,
    BTN_RELEASE = 2'd2
  } btn_evt_t;

  // one framed packet, overflow already screened out
  typedef struct packed {
    logic [7:0] header;
    logic [7:0] x_byte;
    logic [7:0] y_byte;
  } packet_t;

  function automatic btn_evt_t button_event(input logic now, input logic prior);
    btn_evt_t evt;
    if (now) begin
      evt = BTN_PRESS;
    end else if (prior) begin
      evt = BTN_RELEASE;
    end else begin
      evt = BTN_NONE;
    end
    return evt;
  endfunction

endpackage

`default_nettype wire

/* src/ps2mt_intf.sv */
// Channel interfaces of the cursor tracker: byte input, result output and
// register write port. No dependencies.
`default_nettype none

interface ps2mt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface ps2mt_out_if;
  logic        valid;
  logic        ready;
  logic [12:0] cursor_x;
  logic [12:0] cursor_y;
  logic        cursor_visible;
  logic        hide_typing_cursor;
  logic [1:0]  button1_event;
  logic [1:0]  button2_event;
  logic [1:0]  button3_event;

  modport source (output valid, output cursor_x, output cursor_y, output cursor_visible,
                  output hide_typing_cursor, output button1_event,
                  output button2_event, output button3_event, input ready);
  modport sink   (input valid, input cursor_x, input cursor_y, input cursor_visible,
                  input hide_typing_cursor, input button1_event,
                  input button2_event, input button3_event, output ready);
endinterface

interface ps2mt_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [12:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* src/ps2mt_cfg_regs.sv */
// Screen limit registers written through the configuration channel.
// Depends on ps2mt_pkg and ps2mt_cfg_if.
`default_nettype none

module ps2mt_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  ps2mt_cfg_if.sink                          cfg_ch,
  output logic [ps2mt_pkg::SCREEN_BITS-1:0]  screen_width,
  output logic [ps2mt_pkg::SCREEN_BITS-1:0]  screen_height
);
  import ps2mt_pkg::*;

  logic [SCREEN_BITS-1:0] width_r, width_nxt;
  logic [SCREEN_BITS-1:0] height_r, height_nxt;
  logic                   wr_fire;

  assign cfg_ch.ready = 1'b1;
  assign wr_fire      = cfg_ch.valid && cfg_ch.ready;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    // writes to unknown indexes are dropped
    if (wr_fire && cfg_ch.index == CFG_SCREEN_WIDTH) begin
      width_nxt = cfg_ch.data;
    end
    if (wr_fire && cfg_ch.index == CFG_SCREEN_HEIGHT) begin
      height_nxt = cfg_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SCREEN_WIDTH_RST;
      height_r <= SCREEN_HEIGHT_RST;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  assign screen_width  = width_r;
  assign screen_height = height_r;

endmodule

`default_nettype wire

/* src/ps2mt_framer.sv */
// Frames incoming mouse bytes into 3-byte packets and holds one packet in
// a register for the cursor stage. Depends on ps2mt_pkg and ps2mt_in_if.
`default_nettype none

module ps2mt_framer (
  input  wire logic            clk,
  input  wire logic            rst_n,
  ps2mt_in_if.sink             in_ch,
  input  wire logic            pkt_take,
  output logic                 pkt_valid,
  output ps2mt_pkg::packet_t   pkt
);
  import ps2mt_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] header_r, header_nxt;
  logic [7:0] x_byte_r, x_byte_nxt;
  logic       pkt_valid_r, pkt_valid_nxt;
  packet_t    pkt_r, pkt_nxt;
  logic       in_fire;
  logic       pkt_load;

  // the held packet leaves in the same cycle a new byte comes in
  assign in_ch.ready = !pkt_valid_r || pkt_take;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    phase_nxt  = phase_r;
    header_nxt = header_r;
    x_byte_nxt = x_byte_r;
    pkt_load   = 1'b0;
    pkt_nxt    = pkt_r;
    if (in_fire) begin
      unique case (phase_r)
        PH_X: begin
          x_byte_nxt = in_ch.data_byte;
          phase_nxt  = PH_Y;
        end
        PH_Y: begin
          phase_nxt = PH_HEADER;
          // drop packets with either overflow bit
          if (!header_r[HDR_Y_OVF] && !header_r[HDR_X_OVF]) begin
            pkt_load = 1'b1;
            pkt_nxt  = '{header: header_r, x_byte: x_byte_r, y_byte: in_ch.data_byte};
          end
        end
        default: begin
          header_nxt = in_ch.data_byte;
          phase_nxt  = in_ch.data_byte[HDR_SYNC] ? PH_X : PH_HEADER;
        end
      endcase
    end
  end

  always_comb begin
    pkt_valid_nxt = pkt_valid_r;
    if (pkt_load) begin
      pkt_valid_nxt = 1'b1;
    end else if (pkt_take) begin
      pkt_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      header_r    <= '0;
      x_byte_r    <= '0;
      pkt_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      header_r    <= header_nxt;
      x_byte_r    <= x_byte_nxt;
      pkt_valid_r <= pkt_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pkt_r <= pkt_nxt;
  end

  assign pkt_valid = pkt_valid_r;
  assign pkt       = pkt_r;

endmodule

`default_nettype wire

/* src/ps2mt_cursor.sv */
// Applies a framed packet to the cursor position, tracks buttons and the
// visible flag, and holds the result beat. Depends on ps2mt_pkg, ps2mt_out_if.
`default_nettype none

module ps2mt_cursor #(
  parameter int CoordBits = ps2mt_pkg::COORD_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              pkt_valid,
  input  wire ps2mt_pkg::packet_t                pkt,
  output logic                                   pkt_take,
  input  wire logic [ps2mt_pkg::SCREEN_BITS-1:0] screen_width,
  input  wire logic [ps2mt_pkg::SCREEN_BITS-1:0] screen_height,
  ps2mt_out_if.source                            out_ch
);
  import ps2mt_pkg::*;

  // signed work width: room for the larger of coordinate and limit, plus
  // sign and the carry of a 9-bit delta
  localparam int WideBits = ((CoordBits > SCREEN_BITS) ? CoordBits : SCREEN_BITS) + 2;
  localparam logic [WideBits-1:0] CoordMax = WideBits'((1 << CoordBits) - 1);

  logic [CoordBits-1:0] pos_x_r, pos_x_nxt;
  logic [CoordBits-1:0] pos_y_r, pos_y_nxt;
  logic [7:0]           prev_hdr_r, prev_hdr_nxt;
  logic                 visible_r, visible_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic [12:0] res_x_r, res_y_r;
  logic        res_vis_r, res_hide_r;
  btn_evt_t    res_b1_r, res_b2_r, res_b3_r;

  logic signed [WideBits-1:0] dx, dy, sum_x, sum_y;
  logic [WideBits-1:0]        lim_x, lim_y, wid_ext, hgt_ext;
  logic                       typing_hide;
  logic                       slot_free;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign pkt_take  = pkt_valid && slot_free;

  always_comb begin
    dx    = WideBits'(signed'({pkt.header[HDR_X_SGN], pkt.x_byte}));
    dy    = WideBits'(signed'({pkt.header[HDR_Y_SGN], pkt.y_byte}));
    sum_x = signed'(WideBits'(pos_x_r)) + dx;
    sum_y = signed'(WideBits'(pos_y_r)) - dy;

    // limit is the register, further held to the largest coordinate
    wid_ext = WideBits'(screen_width);
    hgt_ext = WideBits'(screen_height);
    lim_x   = (wid_ext > CoordMax) ? CoordMax : wid_ext;
    lim_y   = (hgt_ext > CoordMax) ? CoordMax : hgt_ext;

    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    if (sum_x < 0) begin
      pos_x_nxt = '0;
    end else if (unsigned'(sum_x) > lim_x) begin
      pos_x_nxt = CoordBits'(lim_x);
    end else begin
      pos_x_nxt = CoordBits'(sum_x);
    end
    if (sum_y < 0) begin
      pos_y_nxt = '0;
    end else if (unsigned'(sum_y) > lim_y) begin
      pos_y_nxt = CoordBits'(lim_y);
    end else begin
      pos_y_nxt = CoordBits'(sum_y);
    end

    typing_hide  = !prev_hdr_r[HDR_BTN1];
    visible_nxt  = visible_r | typing_hide;
    prev_hdr_nxt = pkt.header;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pkt_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      prev_hdr_r  <= '0;
      visible_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pkt_take) begin
        pos_x_r    <= pos_x_nxt;
        pos_y_r    <= pos_y_nxt;
        prev_hdr_r <= prev_hdr_nxt;
        visible_r  <= visible_nxt;
      end
    end
  end

  // result beat; hold while the sink stalls
  always_ff @(posedge clk) begin
    if (pkt_take) begin
      res_x_r    <= 13'(pos_x_nxt);
      res_y_r    <= 13'(pos_y_nxt);
      res_vis_r  <= visible_nxt;
      res_hide_r <= typing_hide;
      res_b1_r   <= button_event(pkt.header[HDR_BTN1], prev_hdr_r[HDR_BTN1]);
      res_b2_r   <= button_event(pkt.header[HDR_BTN2], prev_hdr_r[HDR_BTN2]);
      res_b3_r   <= button_event(pkt.header[HDR_BTN3], prev_hdr_r[HDR_BTN3]);
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.cursor_x           = res_x_r;
  assign out_ch.cursor_y           = res_y_r;
  assign out_ch.cursor_visible     = res_vis_r;
  assign out_ch.hide_typing_cursor = res_hide_r;
  assign out_ch.button1_event      = res_b1_r;
  assign out_ch.button2_event      = res_b2_r;
  assign out_ch.button3_event      = res_b3_r;

endmodule

`default_nettype wire

/* src/ps2_mouse_packet_cursor_tracker.sv */
// Top level of the PS/2 mouse packet cursor tracker.
// Depends on ps2mt_pkg, the ps2mt interfaces, ps2mt_cfg_regs,
// ps2mt_framer and ps2mt_cursor.
//
//   channel  direction  beat
//   in_ch    sink       one mouse byte (data_byte)
//   out_ch   source     cursor x/y, visible, hide flag, three button events
//   cfg_ch   sink       register index and write data (always ready)
//
// One byte is taken per cycle unless in_ch holds off. The third byte of a
// packet lands in the packet register; the cursor stage then loads the result
// register from it. A stalled result stops the packet register, and in_ch
// holds off only while both are full. Reset is synchronous and restores the
// screen limits.
`default_nettype none

module ps2_mouse_packet_cursor_tracker #(
  parameter int CoordBits = ps2mt_pkg::COORD_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ps2mt_in_if.sink    in_ch,
  ps2mt_out_if.source out_ch,
  ps2mt_cfg_if.sink   cfg_ch
);
  import ps2mt_pkg::*;

  logic [SCREEN_BITS-1:0] screen_width;
  logic [SCREEN_BITS-1:0] screen_height;
  logic                   pkt_valid;
  logic                   pkt_take;
  packet_t                pkt;

  ps2mt_cfg_regs u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_ch        (cfg_ch),
    .screen_width  (screen_width),
    .screen_height (screen_height)
  );

  ps2mt_framer u_framer (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .pkt_take  (pkt_take),
    .pkt_valid (pkt_valid),
    .pkt       (pkt)
  );

  ps2mt_cursor #(
    .CoordBits (CoordBits)
  ) u_cursor (
    .clk           (clk),
    .rst_n         (rst_n),
    .pkt_valid     (pkt_valid),
    .pkt           (pkt),
    .pkt_take      (pkt_take),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .out_ch        (out_ch)
  );

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking bench for the PS/2 mouse packet cursor tracker: predicts each
// cursor report from the mouse byte stream and checks it against u_top.
// Depends on ps2mt_pkg, the ps2mt channel interfaces and the tracker top level.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ps2mt_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 12;
  localparam int MAX_PRINTED   = 40;

  // indexes past the register list; writes to them must change nothing
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNMAPPED_LO = 8'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNMAPPED_HI = 8'hFF;

  typedef enum int {DRIFT_NONE, DRIFT_UP, DRIFT_DOWN} drift_t;

  typedef struct {
    logic [12:0] x;
    logic [12:0] y;
    logic        visible;
    logic        hide;
    btn_evt_t    b1;
    btn_evt_t    b2;
    btn_evt_t    b3;
  } cursor_report_t;

  logic clk;
  logic rst_n;

  ps2mt_in_if  in_if ();
  ps2mt_out_if out_if ();
  ps2mt_cfg_if cfg_if ();

  ps2_mouse_packet_cursor_tracker u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  logic [7:0]     mouse_bytes[$];
  cursor_report_t awaited_reports[$];
  cursor_report_t got_report;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int          errors;
  int          cycle_count;
  int          bytes_taken;
  int          reports_seen;
  int          reg_writes;

  // tracker model state
  logic [12:0] lim_w;
  logic [12:0] lim_h;
  phase_t      frame_phase;
  logic [7:0]  hdr_latch;
  logic [7:0]  x_latch;
  logic [7:0]  last_hdr;
  int          cur_x;
  int          cur_y;
  logic        shown;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic note_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= MAX_PRINTED) begin
      $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
    end
  endtask

  function automatic int signed_delta(input logic [7:0] mag, input logic neg);
    return neg ? int'(mag) - 256 : int'(mag);
  endfunction

  function automatic int clamp_to(input int v, input logic [12:0] lim);
    int top;
    top = int'(lim);
    if (v < 0) v = 0;
    if (v > top) v = top;
    return v;
  endfunction

  function automatic btn_evt_t event_for(input logic now, input logic was);
    if (now) return BTN_PRESS;
    return was ? BTN_RELEASE : BTN_NONE;
  endfunction

  // advance the framing model by one accepted byte; queue a report on a good packet
  task automatic track_mouse_byte(input logic [7:0] b);
    cursor_report_t rep;
    case (frame_phase)
      PH_X: begin
        x_latch     = b;
        frame_phase = PH_Y;
      end
      PH_Y: begin
        frame_phase = PH_HEADER;
        if (!hdr_latch[HDR_Y_OVF] && !hdr_latch[HDR_X_OVF]) begin
          cur_y = clamp_to(cur_y - signed_delta(b, hdr_latch[HDR_Y_SGN]), lim_h);
          cur_x = clamp_to(cur_x + signed_delta(x_latch, hdr_latch[HDR_X_SGN]), lim_w);
          rep.hide = ~last_hdr[HDR_BTN1];
          if (rep.hide) shown = 1'b1;
          rep.x       = cur_x[12:0];
          rep.y       = cur_y[12:0];
          rep.visible = shown;
          rep.b1      = event_for(hdr_latch[HDR_BTN1], last_hdr[HDR_BTN1]);
          rep.b2      = event_for(hdr_latch[HDR_BTN2], last_hdr[HDR_BTN2]);
          rep.b3      = event_for(hdr_latch[HDR_BTN3], last_hdr[HDR_BTN3]);
          last_hdr    = hdr_latch;
          awaited_reports.push_back(rep);
        end
      end
      default: begin
        hdr_latch   = b;
        frame_phase = b[HDR_SYNC] ? PH_X : PH_HEADER;
      end
    endcase
  endtask

  // byte driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        track_mouse_byte(in_if.data_byte);
        bytes_taken++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (mouse_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_if.valid     <= 1'b1;
          in_if.data_byte <= mouse_bytes.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // report monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_if.valid && out_if.ready) begin
        reports_seen++;
        if (awaited_reports.size() == 0) begin
          note_mismatch("report with none awaited, cursor_x", int'(out_if.cursor_x), 0);
        end else begin
          got_report = awaited_reports.pop_front();
          if (out_if.cursor_x !== got_report.x)
            note_mismatch("cursor_x", int'(out_if.cursor_x), int'(got_report.x));
          if (out_if.cursor_y !== got_report.y)
            note_mismatch("cursor_y", int'(out_if.cursor_y), int'(got_report.y));
          if (out_if.cursor_visible !== got_report.visible)
            note_mismatch("cursor_visible", int'(out_if.cursor_visible),
                          int'(got_report.visible));
          if (out_if.hide_typing_cursor !== got_report.hide)
            note_mismatch("hide_typing_cursor", int'(out_if.hide_typing_cursor),
                          int'(got_report.hide));
          if (out_if.button1_event !== got_report.b1)
            note_mismatch("button1_event", int'(out_if.button1_event), int'(got_report.b1));
          if (out_if.button2_event !== got_report.b2)
            note_mismatch("button2_event", int'(out_if.button2_event), int'(got_report.b2));
          if (out_if.button3_event !== got_report.b3)
            note_mismatch("button3_event", int'(out_if.button3_event), int'(got_report.b3));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout: %0d reports still awaited", awaited_reports.size());
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // write both limits, optionally with stray indexes in between; call after a rising edge
  task automatic program_regs(input logic [12:0] w, input logic [12:0] h,
                              input bit add_unmapped);
    logic [CFG_IDX_BITS-1:0] idx [4];
    logic [12:0]             val [4];
    int                      n;
    idx[0] = CFG_SCREEN_WIDTH;
    val[0] = w;
    n      = 1;
    if (add_unmapped) begin
      idx[1] = CFG_UNMAPPED_LO;
      val[1] = 13'($urandom_range(8191));
      idx[2] = CFG_UNMAPPED_HI;
      val[2] = 13'($urandom_range(8191));
      n      = 3;
    end
    idx[n] = CFG_SCREEN_HEIGHT;
    val[n] = h;
    n++;
    for (int i = 0; i < n; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx[i];
      cfg_if.data  <= val[i];
      do @(posedge clk); while (!cfg_if.ready);
      case (idx[i])
        CFG_SCREEN_WIDTH:  lim_w = val[i];
        CFG_SCREEN_HEIGHT: lim_h = val[i];
        default: ;
      endcase
      reg_writes++;
    end
    cfg_if.valid <= 1'b0;
  endtask

  task automatic queue_packet(input drift_t drift);
    logic x_neg;
    logic y_neg;
    logic [2:0] btn;
    case (drift)
      DRIFT_UP: begin
        x_neg = ($urandom_range(99) < 20);
        y_neg = ($urandom_range(99) < 80);
      end
      DRIFT_DOWN: begin
        x_neg = ($urandom_range(99) < 80);
        y_neg = ($urandom_range(99) < 20);
      end
      default: begin
        x_neg = 1'($urandom_range(1));
        y_neg = 1'($urandom_range(1));
      end
    endcase
    btn = 3'($urandom_range(7));
    mouse_bytes.push_back({1'($urandom_range(99) < 6), 1'($urandom_range(99) < 6),
                           y_neg, x_neg, 1'b1, btn});
    mouse_bytes.push_back(8'($urandom_range(255)));
    mouse_bytes.push_back(8'($urandom_range(255)));
  endtask

  // mostly whole packets, some unsynced headers and stray bytes that shift framing
  task automatic queue_traffic(input int n_bytes, input drift_t drift);
    int sent;
    int pick;
    sent = 0;
    while (sent < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        queue_packet(drift);
        sent += 3;
      end else if (pick < 90) begin
        mouse_bytes.push_back(8'($urandom_range(255)) & ~(8'd1 << HDR_SYNC));
        sent++;
      end else begin
        mouse_bytes.push_back(8'($urandom_range(255)));
        sent++;
      end
    end
  endtask

  // hold until every byte is taken and every report is back, then let the pipe empty
  task automatic settle();
    do @(posedge clk);
    while (mouse_bytes.size() != 0 || in_if.valid || awaited_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [7:0] directed [26];
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.data_byte  = 8'h00;
    out_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = '0;
    cfg_if.data      = '0;
    errors           = 0;
    cycle_count      = 0;
    bytes_taken      = 0;
    reports_seen     = 0;
    reg_writes       = 0;
    lim_w            = SCREEN_WIDTH_RST;
    lim_h            = SCREEN_HEIGHT_RST;
    frame_phase      = PH_HEADER;
    hdr_latch        = '0;
    x_latch          = '0;
    last_hdr         = '0;
    cur_x            = 0;
    cur_y            = 0;
    shown            = 1'b0;
    send_idle_pct    = 7;
    recv_idle_pct    = 54;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // unsynced headers, idle packet, full-scale deltas both ways, both overflows,
    // press and release on every button, hold on button 1
    directed = '{8'h00, 8'hF7,
                 8'h08, 8'h00, 8'h00,
                 8'h09, 8'hFF, 8'h00,
                 8'h0F, 8'hFF, 8'hFF,
                 8'h38, 8'h00, 8'h00,
                 8'h4A, 8'h10, 8'h10,
                 8'h8C, 8'h20, 8'h20,
                 8'h29, 8'h7F, 8'h01,
                 8'h1C, 8'hFF, 8'h80};
    foreach (directed[i]) mouse_bytes.push_back(directed[i]);
    settle();

    program_regs(13'd8191, 13'd8191, 1'b1);
    queue_traffic(75, DRIFT_UP);
    settle();

    send_idle_pct = 54;
    recv_idle_pct = 7;
    program_regs(13'd0, 13'd0, 1'b0);
    queue_traffic(45, DRIFT_NONE);
    settle();

    program_regs(13'd100, 13'd60, 1'b1);
    queue_traffic(90, DRIFT_NONE);
    settle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_regs(13'($urandom_range(8191)), 13'($urandom_range(8191)), 1'b0);
    queue_traffic(90, DRIFT_DOWN);
    settle();

    program_regs(SCREEN_WIDTH_RST, SCREEN_HEIGHT_RST, 1'b0);
    queue_traffic(150, DRIFT_UP);
    settle();

    if (awaited_reports.size() != 0) begin
      note_mismatch("reports never delivered", 0, awaited_reports.size());
    end
    $display("run: %0d mouse bytes in, %0d cursor reports checked, %0d register writes",
             bytes_taken, reports_seen, reg_writes);
    $display("limits swept: reset, full scale, zero, small, random; %0d mismatches", errors);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
